/* rtl/c_escape_codec_top_defines.svh */
// Assertion macros for the escape codec
`ifndef C_ESCAPE_CODEC_TOP_DEFINES_SVH
`define C_ESCAPE_CODEC_TOP_DEFINES_SVH

// Check a condition at every clock edge outside reset
`define CEC_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// Check that a trigger is followed by a condition in the next cycle
`define CEC_ASSERT_NEXT(lbl, trig, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |=> (cond)) \
    else $error(msg);

`endif

/* rtl/cec_pkg.sv */
package cec_pkg;

  localparam int unsigned MaxBytes = 4;

  localparam logic CFG_MODE  = 1'b0;
  localparam logic CFG_DELIM = 1'b1;

  typedef struct packed {
    logic [1:0]                   last_idx;
    logic [MaxBytes-1:0][7:0]     data;
    logic                         byte_valid;
    logic                         string_done;
  } cmd_t;

endpackage

/* rtl/cec_front.sv */
module cec_front
  import cec_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_valid_i,
  input  logic       cfg_index_i,
  input  logic [7:0] cfg_data_i,
  input  logic       accept_i,
  input  logic [7:0] in_byte_i,
  input  logic       string_end_i,
  output logic       cmd_push_o,
  output cmd_t       cmd_o
);

  localparam logic [1:0] PH_IDLE   = 2'd0;
  localparam logic [1:0] PH_BSLASH = 2'd1;
  localparam logic [1:0] PH_HEX1   = 2'd2;
  localparam logic [1:0] PH_HEX2   = 2'd3;

  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_LOW_X  = 8'h78;
  localparam logic [7:0] CH_UP_X   = 8'h58;

  logic       mode_q;
  logic [7:0] delim_q;
  logic [1:0] phase_q, phase_d;
  logic [7:0] high_q, high_d;
  logic [2:0] n;
  logic [8:0] esc_hit;
  logic [8:0] unesc_hit;
  logic [7:0] dv;

  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    if (nib < 4'd10) begin
      hex_char = 8'h30 + {4'h0, nib};
    end else begin
      hex_char = 8'h57 + {4'h0, nib};
    end
  endfunction

  function automatic logic [7:0] digit_value(input logic [7:0] c);
    logic is_letter;
    is_letter = (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
    if (is_letter) begin
      digit_value = (c & 8'hDF) - 8'h41 + 8'd10;
    end else begin
      digit_value = c - 8'h30;
    end
  endfunction

  // {hit, letter} for a byte that has a short escape
  function automatic logic [8:0] esc_letter(input logic [7:0] b);
    case (b)
      8'h27:   esc_letter = {1'b1, 8'h27};
      8'h22:   esc_letter = {1'b1, 8'h22};
      8'h07:   esc_letter = {1'b1, 8'h61};
      8'h08:   esc_letter = {1'b1, 8'h62};
      8'h0C:   esc_letter = {1'b1, 8'h66};
      8'h0A:   esc_letter = {1'b1, 8'h6E};
      8'h0D:   esc_letter = {1'b1, 8'h72};
      8'h09:   esc_letter = {1'b1, 8'h74};
      8'h0B:   esc_letter = {1'b1, 8'h76};
      8'h5C:   esc_letter = {1'b1, 8'h5C};
      default: esc_letter = {1'b0, 8'h00};
    endcase
  endfunction

  // {hit, code} for a letter that follows a backslash
  function automatic logic [8:0] esc_code(input logic [7:0] c);
    case (c)
      8'h27:   esc_code = {1'b1, 8'h27};
      8'h22:   esc_code = {1'b1, 8'h22};
      8'h61:   esc_code = {1'b1, 8'h07};
      8'h62:   esc_code = {1'b1, 8'h08};
      8'h66:   esc_code = {1'b1, 8'h0C};
      8'h6E:   esc_code = {1'b1, 8'h0A};
      8'h72:   esc_code = {1'b1, 8'h0D};
      8'h74:   esc_code = {1'b1, 8'h09};
      8'h76:   esc_code = {1'b1, 8'h0B};
      8'h5C:   esc_code = {1'b1, 8'h5C};
      default: esc_code = {1'b0, 8'h00};
    endcase
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= 1'b0;
      delim_q <= 8'h00;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_MODE:  mode_q  <= cfg_data_i[0];
        CFG_DELIM: delim_q <= cfg_data_i;
        default:   mode_q  <= mode_q;
      endcase
    end
  end

  always_comb begin
    esc_hit   = esc_letter(in_byte_i);
    unesc_hit = esc_code(in_byte_i);
    dv        = digit_value(in_byte_i);
    n         = 3'd0;
    phase_d   = phase_q;
    high_d    = high_q;
    cmd_o     = '0;
    cmd_o.byte_valid = 1'b1;
    if (mode_q) begin
      unique case (phase_q)
        PH_IDLE: begin
          if (in_byte_i == CH_BSLASH) begin
            phase_d = PH_BSLASH;
          end else begin
            n = 3'd1;
            cmd_o.data[0] = in_byte_i;
          end
        end
        PH_BSLASH: begin
          if (unesc_hit[8]) begin
            phase_d = PH_IDLE;
            n = 3'd1;
            cmd_o.data[0] = unesc_hit[7:0];
          end else if (in_byte_i == CH_LOW_X || in_byte_i == CH_UP_X) begin
            phase_d = PH_HEX1;
          end else begin
            phase_d = PH_IDLE;
            n = 3'd1;
            cmd_o.data[0] = in_byte_i;
          end
        end
        PH_HEX1: begin
          high_d  = {dv[3:0], 4'h0};
          phase_d = PH_HEX2;
        end
        PH_HEX2: begin
          phase_d = PH_IDLE;
          n = 3'd1;
          cmd_o.data[0] = high_q + dv;
        end
        default: phase_d = PH_IDLE;
      endcase
    end else begin
      phase_d = PH_IDLE;
      high_d  = 8'h00;
      if ((delim_q != 8'h00 && in_byte_i == delim_q) ||
          (!esc_hit[8] && (in_byte_i < 8'h20 || in_byte_i[7]))) begin
        n = 3'd4;
        cmd_o.data[0] = CH_BSLASH;
        cmd_o.data[1] = CH_LOW_X;
        cmd_o.data[2] = hex_char(in_byte_i[7:4]);
        cmd_o.data[3] = hex_char(in_byte_i[3:0]);
      end else if (esc_hit[8]) begin
        n = 3'd2;
        cmd_o.data[0] = CH_BSLASH;
        cmd_o.data[1] = esc_hit[7:0];
      end else begin
        n = 3'd1;
        cmd_o.data[0] = in_byte_i;
      end
    end
    if (string_end_i) begin
      phase_d = PH_IDLE;
      high_d  = 8'h00;
      cmd_o.string_done = 1'b1;
      if (n == 3'd0) begin
        n = 3'd1;
        cmd_o.data[0] = 8'h00;
        cmd_o.byte_valid = 1'b0;
      end
    end
    cmd_o.last_idx = 2'(n - 3'd1);
    cmd_push_o = accept_i && (n != 3'd0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      high_q  <= 8'h00;
    end else if (accept_i) begin
      phase_q <= phase_d;
      high_q  <= high_d;
    end
  end

endmodule

/* rtl/cec_fifo.sv */
`include "c_escape_codec_top_defines.svh"

module cec_fifo
  import cec_pkg::*;
#(
  parameter int unsigned Depth = 4
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t data_i,
  output logic full_o,
  input  logic pop_i,
  output cmd_t data_o,
  output logic empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  cmd_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;

  function automatic logic [PtrW-1:0] next_ptr(input logic [PtrW-1:0] p);
    if (p == PtrW'(Depth - 1)) begin
      next_ptr = '0;
    end else begin
      next_ptr = p + PtrW'(1);
    end
  endfunction

  assign full_o  = (count_q == CntW'(Depth));
  assign empty_o = (count_q == '0);
  assign data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= next_ptr(wr_ptr_q);
      end
      if (pop_i) begin
        rd_ptr_q <= next_ptr(rd_ptr_q);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + CntW'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - CntW'(1);
      end
    end
  end

  `CEC_ASSERT(cnt_range_a, count_q <= CntW'(Depth), "queue count out of range")
  `CEC_ASSERT(no_overflow_a, !(push_i && full_o), "push into full queue")
  `CEC_ASSERT(no_underflow_a, !(pop_i && empty_o), "pop from empty queue")
  `CEC_ASSERT_NEXT(push_fill_a, push_i && !pop_i, !empty_o, "queue empty after push")

endmodule

/* rtl/cec_back.sv */
module cec_back
  import cec_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cmd_empty_i,
  input  cmd_t       cmd_i,
  output logic       cmd_pop_o,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_byte_o,
  output logic       byte_valid_o,
  output logic       run_last_o,
  output logic       string_done_o
);

  logic [1:0] idx_q;
  logic       ovalid_q;
  logic       load;
  logic       at_last;

  assign at_last   = (idx_q == cmd_i.last_idx);
  assign load      = !cmd_empty_i && (!ovalid_q || pop);
  assign cmd_pop_o = load && at_last;
  assign empty     = !ovalid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q    <= 2'd0;
      ovalid_q <= 1'b0;
    end else begin
      if (load) begin
        ovalid_q <= 1'b1;
        idx_q    <= at_last ? 2'd0 : idx_q + 2'd1;
      end else if (pop) begin
        ovalid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_byte_o    <= cmd_i.data[idx_q];
      byte_valid_o  <= cmd_i.byte_valid;
      run_last_o    <= at_last;
      string_done_o <= at_last && cmd_i.string_done;
    end
  end

endmodule

/* rtl/c_escape_codec_top.sv */
// An item's commands are queued when it is accepted; its first result is then
// loaded into the output register when the queue ahead is empty and the register is free.
// Throughput: one result per cycle while pop is held; an item with k results (1 to 4)
// occupies the emitter until its last result is loaded, and the command queue of Depth
// entries lets intake run ahead. Items producing no result are handled at intake only.
// Reset (rst_ni low, asynchronous): queue emptied, decoder idle, escape mode, no delimiter.
module c_escape_codec_top
  import cec_pkg::*;
#(
  parameter int unsigned Depth = 4
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push,
  output logic       full,
  input  logic [7:0] in_byte_i,
  input  logic       string_end_i,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_byte_o,
  output logic       byte_valid_o,
  output logic       run_last_o,
  output logic       string_done_o,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic       cfg_index_i,
  input  logic [7:0] cfg_data_i
);

  logic accept;
  logic cmd_push;
  logic cmd_pop;
  logic cmd_empty;
  cmd_t cmd_in;
  cmd_t cmd_head;

  assign cfg_ready_o = 1'b1;
  assign accept      = push && !full;

  cec_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .accept_i     (accept),
    .in_byte_i    (in_byte_i),
    .string_end_i (string_end_i),
    .cmd_push_o   (cmd_push),
    .cmd_o        (cmd_in)
  );

  cec_fifo #(
    .Depth (Depth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .data_i  (cmd_in),
    .full_o  (full),
    .pop_i   (cmd_pop),
    .data_o  (cmd_head),
    .empty_o (cmd_empty)
  );

  cec_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_empty_i   (cmd_empty),
    .cmd_i         (cmd_head),
    .cmd_pop_o     (cmd_pop),
    .empty         (empty),
    .pop           (pop),
    .out_byte_o    (out_byte_o),
    .byte_valid_o  (byte_valid_o),
    .run_last_o    (run_last_o),
    .string_done_o (string_done_o)
  );

endmodule

/* tb/sv/testbench.sv */
`timescale 1ns / 100ps

module testbench;
  import cec_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam logic [7:0] BSLASH = 8'h5C;
  localparam logic [7:0] ESC_CODE [10] =
    '{8'h27, 8'h22, 8'h07, 8'h08, 8'h0C, 8'h0A, 8'h0D, 8'h09, 8'h0B, 8'h5C};
  localparam logic [7:0] ESC_LETTER [10] =
    '{8'h27, 8'h22, 8'h61, 8'h62, 8'h66, 8'h6E, 8'h72, 8'h74, 8'h76, 8'h5C};

  typedef enum logic [1:0] {DEC_IDLE, DEC_BSLASH, DEC_HEX1, DEC_HEX2} dec_phase_e;
  typedef enum logic [1:0] {ROW_ITEM, ROW_MODE, ROW_DELIM} row_kind_e;

  typedef struct packed {
    logic [7:0] data;
    logic       valid;
    logic       last;
    logic       done;
  } byte_out_t;

  typedef struct packed {
    row_kind_e   kind;
    logic [7:0]  value;
    logic        fin;
    logic [2:0]  n_typed;
    logic        bare;
    logic [31:0] typed;
  } row_t;

  localparam int N_ROWS = 31;
  localparam row_t DIR_ROWS [N_ROWS] = '{
    '{ROW_ITEM,  8'h41, 1'b0, 3'd1, 1'b0, 32'h41000000},
    '{ROW_ITEM,  8'h00, 1'b0, 3'd4, 1'b0, 32'h5C783030},
    '{ROW_ITEM,  8'hFF, 1'b0, 3'd4, 1'b0, 32'h5C786666},
    '{ROW_ITEM,  8'h0A, 1'b0, 3'd2, 1'b0, 32'h5C6E0000},
    '{ROW_ITEM,  8'h5C, 1'b0, 3'd2, 1'b0, 32'h5C5C0000},
    '{ROW_ITEM,  8'h7F, 1'b0, 3'd1, 1'b0, 32'h7F000000},
    '{ROW_ITEM,  8'h80, 1'b1, 3'd4, 1'b0, 32'h5C783830},
    '{ROW_DELIM, 8'h41, 1'b0, 3'd0, 1'b0, 32'h0},
    '{ROW_ITEM,  8'h41, 1'b0, 3'd4, 1'b0, 32'h5C783431},
    '{ROW_ITEM,  8'h22, 1'b1, 3'd2, 1'b0, 32'h5C220000},
    '{ROW_MODE,  8'h01, 1'b0, 3'd0, 1'b0, 32'h0},
    '{ROW_DELIM, 8'hFF, 1'b0, 3'd0, 1'b0, 32'h0},
    '{ROW_ITEM,  8'h5C, 1'b0, 3'd0, 1'b0, 32'h0},
    '{ROW_ITEM,  8'h6E, 1'b0, 3'd1, 1'b0, 32'h0A000000},
    '{ROW_ITEM,  8'h5C, 1'b0, 3'd0, 1'b0, 32'h0},
    '{ROW_ITEM,  8'h78, 1'b0, 3'd0, 1'b0, 32'h0},
    '{ROW_ITEM,  8'h66, 1'b0, 3'd0, 1'b0, 32'h0},
    '{ROW_ITEM,  8'h46, 1'b0, 3'd1, 1'b0, 32'hFF000000},
    '{ROW_ITEM,  8'h5C, 1'b0, 3'd0, 1'b0, 32'h0},
    '{ROW_ITEM,  8'h58, 1'b0, 3'd0, 1'b0, 32'h0},
    '{ROW_ITEM,  8'h67, 1'b0, 3'd0, 1'b0, 32'h0},
    '{ROW_ITEM,  8'h7A, 1'b0, 3'd0, 1'b0, 32'h0},
    '{ROW_ITEM,  8'h5C, 1'b0, 3'd0, 1'b0, 32'h0},
    '{ROW_ITEM,  8'h71, 1'b0, 3'd1, 1'b0, 32'h71000000},
    '{ROW_ITEM,  8'h5C, 1'b1, 3'd1, 1'b1, 32'h0},
    '{ROW_ITEM,  8'h00, 1'b1, 3'd1, 1'b0, 32'h0},
    '{ROW_ITEM,  8'h5C, 1'b0, 3'd0, 1'b0, 32'h0},
    '{ROW_ITEM,  8'h78, 1'b1, 3'd1, 1'b1, 32'h0},
    '{ROW_ITEM,  8'h5C, 1'b0, 3'd0, 1'b0, 32'h0},
    '{ROW_MODE,  8'h00, 1'b0, 3'd0, 1'b0, 32'h0},
    '{ROW_ITEM,  8'h5C, 1'b1, 3'd2, 1'b0, 32'h5C5C0000}
  };

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       push = 1'b0;
  logic       full;
  logic [7:0] in_byte_i = 8'h00;
  logic       string_end_i = 1'b0;
  logic       empty;
  logic       pop = 1'b0;
  logic [7:0] out_byte_o;
  logic       byte_valid_o;
  logic       run_last_o;
  logic       string_done_o;
  logic       cfg_valid_i = 1'b0;
  logic       cfg_ready_o;
  logic       cfg_index_i = 1'b0;
  logic [7:0] cfg_data_i = 8'h00;

  logic       full_s = 1'b1;
  logic       empty_s = 1'b1;
  logic       ready_s = 1'b0;
  byte_out_t  seen;
  byte_out_t  want;

  logic       unesc_on = 1'b0;
  logic [7:0] delim_byte = 8'h00;
  dec_phase_e dec_phase = DEC_IDLE;
  logic [7:0] hi_sum = 8'h00;
  byte_out_t  step_out [4];
  int         step_n;
  byte_out_t  pending_bytes [$];

  int          err_cnt = 0;
  int          phase_items;
  int          stall_left = 0;
  bit          rx_idle = 1'b1;
  bit          rx_hold = 1'b0;
  int unsigned cycle_cnt = 0;
  event        hold_ev;

  c_escape_codec_top DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push         (push),
    .full         (full),
    .in_byte_i    (in_byte_i),
    .string_end_i (string_end_i),
    .empty        (empty),
    .pop          (pop),
    .out_byte_o   (out_byte_o),
    .byte_valid_o (byte_valid_o),
    .run_last_o   (run_last_o),
    .string_done_o(string_done_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  always @(negedge clk_i) begin
    full_s  <= full;
    empty_s <= empty;
    ready_s <= cfg_ready_o;
    seen    <= '{out_byte_o, byte_valid_o, run_last_o, string_done_o};
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("testbench: done, errors");
      $finish;
    end
  end

  function automatic void emit(input logic [7:0] b);
    step_out[step_n] = '{b, 1'b1, 1'b0, 1'b0};
    step_n++;
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] v);
    return (v < 4'd10) ? 8'h30 + v : 8'h57 + v;
  endfunction

  function automatic void emit_hex(input logic [7:0] b);
    emit(BSLASH);
    emit(8'h78);
    emit(hex_char(b[7:4]));
    emit(hex_char(b[3:0]));
  endfunction

  function automatic logic [7:0] digit_of(input logic [7:0] c);
    if ((c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A))
      return (c & 8'hDF) - 8'h41 + 8'd10;
    return c - 8'h30;
  endfunction

  function automatic void codec_step(input logic [7:0] b, input logic fin);
    int i;
    bit hit;
    step_n = 0;
    hit = 1'b0;
    if (unesc_on) begin
      case (dec_phase)
        DEC_IDLE: begin
          if (b == BSLASH) dec_phase = DEC_BSLASH;
          else emit(b);
        end
        DEC_BSLASH: begin
          for (i = 0; i < 10; i++)
            if (!hit && b == ESC_LETTER[i]) begin
              emit(ESC_CODE[i]);
              hit = 1'b1;
            end
          if (hit) begin
            dec_phase = DEC_IDLE;
          end else if (b == 8'h78 || b == 8'h58) begin
            dec_phase = DEC_HEX1;
          end else begin
            dec_phase = DEC_IDLE;
            emit(b);
          end
        end
        DEC_HEX1: begin
          hi_sum = digit_of(b) << 4;
          dec_phase = DEC_HEX2;
        end
        default: begin
          dec_phase = DEC_IDLE;
          emit(hi_sum + digit_of(b));
        end
      endcase
    end else begin
      dec_phase = DEC_IDLE;
      hi_sum = 8'h00;
      if (delim_byte != 8'h00 && b == delim_byte) begin
        emit_hex(b);
      end else begin
        for (i = 0; i < 10; i++)
          if (!hit && b == ESC_CODE[i]) begin
            emit(BSLASH);
            emit(ESC_LETTER[i]);
            hit = 1'b1;
          end
        if (!hit) begin
          if (b < 8'h20 || b >= 8'h80) emit_hex(b);
          else emit(b);
        end
      end
    end
    if (fin) begin
      dec_phase = DEC_IDLE;
      hi_sum = 8'h00;
      if (step_n == 0) begin
        emit(8'h00);
        step_out[0].valid = 1'b0;
      end
      step_out[step_n-1].done = 1'b1;
    end
    if (step_n > 0) step_out[step_n-1].last = 1'b1;
  endfunction

  function automatic void queue_step();
    int k;
    for (k = 0; k < step_n; k++) pending_bytes.insert(pending_bytes.size(), step_out[k]);
  endfunction

  function automatic logic [7:0] hex_pick();
    int v;
    v = $urandom_range(0, 21);
    if (v < 10) return 8'h30 + 8'(v);
    if (v < 16) return 8'h57 + 8'(v);
    return 8'h31 + 8'(v);
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic fin);
    push <= 1'b1;
    in_byte_i <= b;
    string_end_i <= fin;
    do @(posedge clk_i); while (full_s);
    codec_step(b, fin);
  endtask

  task automatic settle();
    push <= 1'b0;
    while (pending_bytes.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic idx, input logic [7:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!ready_s);
    if (idx == CFG_MODE) unesc_on = val[0];
    else delim_byte = val;
  endtask

  task automatic send_string(input bit gaps_on);
    logic [7:0] str [$];
    int len;
    int pick;
    int k;
    len = $urandom_range(1, 10);
    while (str.size() < len) begin
      pick = $urandom_range(0, 9);
      if (!unesc_on) begin
        if (pick < 2) str.insert(str.size(), ESC_CODE[$urandom_range(0, 9)]);
        else if (pick < 3) str.insert(str.size(), delim_byte);
        else str.insert(str.size(), 8'($urandom_range(0, 255)));
      end else if (pick < 3) begin
        str.insert(str.size(), 8'($urandom_range(0, 255)));
      end else begin
        str.insert(str.size(), BSLASH);
        if (pick < 5) begin
          str.insert(str.size(), ESC_LETTER[$urandom_range(0, 9)]);
        end else if (pick < 8) begin
          str.insert(str.size(), $urandom_range(0, 1) ? 8'h78 : 8'h58);
          str.insert(str.size(), hex_pick());
          str.insert(str.size(), hex_pick());
        end else if (pick == 8) begin
          str.insert(str.size(), 8'h78);
          str.insert(str.size(), 8'($urandom_range(0, 255)));
          str.insert(str.size(), 8'($urandom_range(0, 255)));
        end else begin
          str.insert(str.size(), 8'($urandom_range(0, 255)));
        end
      end
    end
    // cut the tail now and then to leave a sequence open at the string end
    if (unesc_on && str.size() > 1 && $urandom_range(0, 4) == 0) void'(str.pop_back());
    for (k = 0; k < str.size(); k++) begin
      if (gaps_on && !rx_hold && $urandom_range(0, 5) == 0) begin
        push <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk_i);
      end
      send_byte(str[k], k == str.size() - 1);
      queue_step();
      phase_items++;
    end
  endtask

  initial begin
    forever begin
      @(hold_ev);
      rx_hold = 1'b1;
      repeat (80) @(posedge clk_i);
      rx_hold = 1'b0;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (pop && !empty_s) begin
        if (pending_bytes.size() == 0) begin
          err_cnt++;
          $display("%0t: expected no item, actual data %h valid %b last %b done %b",
                   $time, seen.data, seen.valid, seen.last, seen.done);
        end else begin
          want = pending_bytes.pop_front();
          if (seen !== want) begin
            err_cnt++;
            $display("%0t: expected data %h valid %b last %b done %b, actual %h %b %b %b",
                     $time, want.data, want.valid, want.last, want.done,
                     seen.data, seen.valid, seen.last, seen.done);
          end
        end
      end
      if (rx_hold || stall_left != 0) begin
        pop <= 1'b0;
        if (stall_left != 0) stall_left = stall_left - 1;
      end else if (rx_idle && $urandom_range(0, 9) == 0) begin
        pop <= 1'b0;
        stall_left = $urandom_range(0, 18);
      end else begin
        pop <= 1'b1;
      end
    end
  end

  initial begin
    int k;
    int j;
    int p;
    byte_out_t w;
    logic [7:0] dlm;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (k = 0; k < N_ROWS; k++) begin
      case (DIR_ROWS[k].kind)
        ROW_MODE, ROW_DELIM: begin
          settle();
          write_reg(DIR_ROWS[k].kind == ROW_MODE ? CFG_MODE : CFG_DELIM, DIR_ROWS[k].value);
          cfg_valid_i <= 1'b0;
        end
        default: begin
          send_byte(DIR_ROWS[k].value, DIR_ROWS[k].fin);
          if (DIR_ROWS[k].n_typed == 0) begin
            queue_step();
          end else begin
            for (j = 0; j < DIR_ROWS[k].n_typed; j++) begin
              w.data  = DIR_ROWS[k].typed[31-8*j -: 8];
              w.valid = !DIR_ROWS[k].bare;
              w.last  = (j == DIR_ROWS[k].n_typed - 1);
              w.done  = DIR_ROWS[k].fin && w.last;
              pending_bytes.insert(pending_bytes.size(), w);
            end
          end
        end
      endcase
    end

    for (p = 0; p < 6; p++) begin
      settle();
      if (p < 2) dlm = 8'h00;
      else if (p == 2) dlm = 8'hFF;
      else dlm = 8'($urandom_range(0, 255));
      write_reg(CFG_MODE, (p == 5) ? 8'($urandom_range(0, 1)) : 8'(p % 2));
      write_reg(CFG_DELIM, dlm);
      cfg_valid_i <= 1'b0;
      rx_idle = (p < 5);
      // stall the output early on so the block backs up into its input
      if (p == 0) -> hold_ev;
      phase_items = 0;
      while (phase_items < 20) send_string(p < 5 && $urandom_range(0, 2) != 0);
    end

    settle();
    if (err_cnt == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+rtl
rtl/cec_pkg.sv
rtl/cec_front.sv
rtl/cec_fifo.sv
rtl/cec_back.sv
rtl/c_escape_codec_top.sv
tb/sv/testbench.sv
